// ===== rtl/core/unsigned_decimal_field_formatter_assert.svh =====
// Assertion macros for the formatter RTL.
// Depends on nothing; included by udff_back, the only module that carries assertions.
`ifndef UNSIGNED_DECIMAL_FIELD_FORMATTER_ASSERT_SVH
`define UNSIGNED_DECIMAL_FIELD_FORMATTER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define UDFF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("udff assertion failed");

// Check that cons holds in the cycle after ante.
`define UDFF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("udff assertion failed");

`endif

// ===== rtl/core/udff_pkg.sv =====
// Types and constants of the unsigned decimal field formatter.
// Depends on nothing; imported by every formatter module.
package udff_pkg;

    localparam int          CNT_W         = 7;
    localparam logic [CNT_W-1:0] MAX_WIDTH = 7'd64;
    localparam int          NUM_DIGITS    = 10;
    localparam int          CONV_STEPS    = 8;
    localparam int          BITS_PER_STEP = 4;
    localparam int          STEP_W        = 3;
    localparam logic [7:0]  CHAR_SPACE    = 8'h20;
    localparam logic [7:0]  CHAR_ZERO     = 8'h30;

    typedef struct packed {
        logic [31:0]        value;
        logic [6:0]         field_width;
        logic signed [7:0]  precision;
        logic               left_align;
        logic               zero_pad;
    } t_fmt_in;

    typedef struct packed {
        logic [7:0]         char_code;
        logic               last;
        logic [6:0]         total_count;
    } t_fmt_out;

    typedef logic [NUM_DIGITS-1:0][3:0] t_bcd;

    // One classified field, ready to be spelled out character by character.
    typedef struct packed {
        t_bcd               digits;
        logic [CNT_W-1:0]   pad_lead;
        logic [CNT_W-1:0]   dig_start;
        logic [CNT_W-1:0]   dig_end;
        logic [CNT_W-1:0]   total;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } t_front_state;

endpackage

// ===== rtl/core/udff_front.sv =====
// Front end: accepts a conversion request, converts the value to BCD and
// works out the padding layout. Depends on udff_pkg.
module udff_front import udff_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_fmt_in   i_item,
    input  logic      i_q_full,
    output logic      o_q_push,
    output t_job      o_q_job
);

    t_front_state     r_state, n_state;
    logic [31:0]      r_bin;
    t_bcd             r_bcd;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0] r_width;
    logic [CNT_W-1:0] r_prec;
    logic             r_has_prec;
    logic             r_left;
    logic             r_zpad;

    logic             accept;
    t_bcd             bcd_next;
    logic [CNT_W-1:0] width_sat;
    logic [CNT_W-1:0] prec_sat;
    logic [3:0]       ndig_raw;
    logic [CNT_W-1:0] ndig;
    logic [CNT_W-1:0] zeros;
    logic [CNT_W-1:0] spaces;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] pad_lead;
    logic [CNT_W-1:0] total;
    logic             no_digits;

    // Shift one binary bit into the BCD register, add-3 correction first.
    function automatic t_bcd dabble(input t_bcd d, input logic b);
        t_bcd adj;
        t_bcd res;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i] = (d[i] >= 4'd5) ? d[i] + 4'd3 : d[i];
        end
        res[0] = {adj[0][2:0], b};
        for (int i = 1; i < NUM_DIGITS; i++) begin
            res[i] = {adj[i][2:0], adj[i-1][3]};
        end
        return res;
    endfunction

    assign full   = (r_state != F_IDLE);
    assign accept = push && !full;

    // Saturate width and precision on the way in.
    always_comb begin
        width_sat = (i_item.field_width > MAX_WIDTH) ? MAX_WIDTH : i_item.field_width;
        prec_sat  = (i_item.precision[6:0] > MAX_WIDTH) ? MAX_WIDTH
                                                        : i_item.precision[6:0];
    end

    // Four conversion bits per cycle.
    always_comb begin
        bcd_next = r_bcd;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            bcd_next = dabble(bcd_next, r_bin[31-k]);
        end
    end

    // Classify the field: digit count, zeros, spaces and segment bounds.
    always_comb begin
        ndig_raw = 4'd1;
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                ndig_raw = 4'(i + 1);
            end
        end
        no_digits = r_has_prec && (r_prec == '0) && (r_bcd == '0);
        ndig      = no_digits ? '0 : CNT_W'(ndig_raw);
        zeros     = '0;
        if (r_has_prec && (r_prec > ndig)) begin
            zeros = r_prec - ndig;
        end
        if (!r_has_prec && !r_left && r_zpad && (r_width > ndig)) begin
            zeros = r_width - ndig;
        end
        used     = ndig + zeros;
        spaces   = (r_width > used) ? r_width - used : '0;
        total    = used + spaces;
        pad_lead = r_left ? '0 : spaces;

        o_q_job.digits    = r_bcd;
        o_q_job.pad_lead  = pad_lead;
        o_q_job.dig_start = pad_lead + zeros;
        o_q_job.dig_end   = pad_lead + used;
        o_q_job.total     = total;
    end

    // Next state: drop empty fields, otherwise wait for queue space.
    always_comb begin
        n_state  = r_state;
        o_q_push = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = F_CONV;
                end
            end
            F_CONV: begin
                if (r_step == STEP_W'(CONV_STEPS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (total == '0) begin
                    n_state = F_IDLE;
                end else if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // Hold the state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request and advance the conversion.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bin      <= i_item.value;
            r_bcd      <= '0;
            r_step     <= '0;
            r_width    <= width_sat;
            r_prec     <= prec_sat;
            r_has_prec <= !i_item.precision[7];
            r_left     <= i_item.left_align;
            r_zpad     <= i_item.zero_pad;
        end else if (r_state == F_CONV) begin
            r_bin  <= {r_bin[31-BITS_PER_STEP:0], {BITS_PER_STEP{1'b0}}};
            r_bcd  <= bcd_next;
            r_step <= r_step + STEP_W'(1);
        end
    end

endmodule

// ===== rtl/core/udff_queue.sv =====
// Two-entry queue of classified fields between front and back end.
// Depends on udff_pkg.
module udff_queue import udff_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       wr_en;
    logic       rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Advance pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    // Store the entry.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/core/udff_back.sv =====
// Back end: spells out one classified field, one character a cycle while its
// output is popped, into a one-entry output register. Depends on udff_pkg and the assert macros.
`include "unsigned_decimal_field_formatter_assert.svh"
module udff_back import udff_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_job     i_job,
    input  logic     i_q_empty,
    output logic     o_q_pop,
    output logic     empty,
    input  logic     pop,
    output t_fmt_out o_result
);

    t_job             r_job;
    logic             r_busy;
    logic [CNT_W-1:0] r_pos;
    logic             r_out_valid;
    t_fmt_out         r_out;

    logic             out_take;
    logic             advance;
    logic             is_last;
    logic [CNT_W-1:0] dig_off;
    logic [3:0]       dig_idx;
    logic [7:0]       ch;

    assign empty    = !r_out_valid;
    assign o_result = r_out;
    assign out_take = pop && r_out_valid;
    assign advance  = r_busy && (!r_out_valid || out_take);
    assign o_q_pop  = !r_busy && !i_q_empty;
    assign is_last  = (r_pos == r_job.total - CNT_W'(1));

    // Pick the character at the current position.
    always_comb begin
        dig_off = r_job.dig_end - CNT_W'(1) - r_pos;
        dig_idx = dig_off[3:0];
        if (r_pos < r_job.pad_lead) begin
            ch = CHAR_SPACE;
        end else if (r_pos < r_job.dig_start) begin
            ch = CHAR_ZERO;
        end else if (r_pos < r_job.dig_end) begin
            ch = CHAR_ZERO + {4'd0, r_job.digits[dig_idx]};
        end else begin
            ch = CHAR_SPACE;
        end
    end

    // Load a field and walk its positions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_pos  <= '0;
        end else if (advance) begin
            r_pos <= r_pos + CNT_W'(1);
            if (is_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_job;
        end
    end

    // Hold the result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.char_code   <= ch;
            r_out.last        <= is_last;
            r_out.total_count <= is_last ? r_job.total : '0;
        end
    end

    `UDFF_ASSERT_IMP(a_last_has_count, i_clk, i_rst_n,
        r_out_valid && r_out.last, r_out.total_count != '0)
    `UDFF_ASSERT_IMP(a_count_only_last, i_clk, i_rst_n,
        r_out_valid && !r_out.last, r_out.total_count == '0)
    `UDFF_ASSERT_NEXT(a_stall_holds_pos, i_clk, i_rst_n,
        r_busy && r_out_valid && !pop, $stable(r_pos) && r_busy)
    `UDFF_ASSERT_IMP(a_pos_in_field, i_clk, i_rst_n,
        r_busy, r_pos < r_job.total)

endmodule

// ===== rtl/core/unsigned_decimal_field_formatter.sv =====
// After accept, a field goes through 8 BCD conversion steps of 4 bits, then
// classify and queue write, back-end load and the output register.
// The back end gives one character per cycle while the output is popped; the
// front end takes no new request until the current field is pushed or dropped.
// Empty fields give no characters. Synchronous active-low reset clears control
// state but for the step counter; queue storage and payload registers are not reset.
module unsigned_decimal_field_formatter import udff_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_fmt_in  i_item,
    output logic     empty,
    input  logic     pop,
    output t_fmt_out o_result
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_job q_in_job;
    t_job q_out_job;

    udff_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_in_job)
    );

    udff_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_empty (q_empty)
    );

    udff_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (q_out_job),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the unsigned decimal field formatter.
// Depends on udff_pkg and unsigned_decimal_field_formatter; predicts every
// character of each %u field and checks the result stream beat by beat.
`timescale 1ns / 1ps

module tb_top import udff_pkg::*; ();

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     push    = 1'b0;
    logic     full;
    t_fmt_in  i_item  = '0;
    logic     empty;
    logic     pop     = 1'b0;
    t_fmt_out o_result;

    // Characters still owed by the block, oldest first.
    t_fmt_out exp_chars[$];
    int       mismatch_count = 0;
    bit       steady = 1'b0;

    unsigned_decimal_field_formatter u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    // Spell out one %u field and append its characters to the expected stream.
    function automatic void spell_field(input t_fmt_in f);
        logic [3:0]  dig [NUM_DIGITS];
        logic [31:0] v;
        logic        has_prec;
        int          cap, width, prec, ndig, zeros, spaces, i, k;
        t_fmt_out    ch;
        t_fmt_out    field[$];
        cap      = int'(MAX_WIDTH);
        width    = int'(f.field_width);
        has_prec = !f.precision[7];
        prec     = has_prec ? int'(f.precision[6:0]) : 0;
        if (width > cap) width = cap;
        if (prec > cap) prec = cap;

        // Collect digits, least significant first; zero at precision 0 has none.
        ndig = 0;
        if (!(has_prec && prec == 0 && f.value == 32'd0)) begin
            v = f.value;
            do begin
                dig[ndig] = 4'(v % 10);
                ndig++;
                v = v / 10;
            end while (v != 0 && ndig < NUM_DIGITS);
        end

        zeros  = 0;
        spaces = 0;
        if (has_prec && prec > ndig) zeros = prec - ndig;
        if (!has_prec && !f.left_align && f.zero_pad && width > ndig) zeros = width - ndig;
        if (width > ndig + zeros) spaces = width - ndig - zeros;

        ch = '0;
        ch.char_code = CHAR_SPACE;
        if (!f.left_align) repeat (spaces) field.push_back(ch);
        ch.char_code = CHAR_ZERO;
        repeat (zeros) field.push_back(ch);
        for (i = ndig - 1; i >= 0; i--) begin
            ch.char_code = CHAR_ZERO + 8'(dig[i]);
            field.push_back(ch);
        end
        ch.char_code = CHAR_SPACE;
        if (f.left_align) repeat (spaces) field.push_back(ch);

        // Mark the closing character with the field length.
        k = field.size();
        if (k > 0) begin
            field[k-1].last        = 1'b1;
            field[k-1].total_count = 7'(k);
        end
        foreach (field[j]) exp_chars.push_back(field[j]);
    endfunction

    // Offer one item, with a random gap first outside the steady stream, and hold it until accepted.
    task automatic send_field(input t_fmt_in f);
        while (!steady && $urandom_range(99) < 28) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= f;
        do @(posedge i_clk); while (full);
        spell_field(f);
    endtask

    task automatic send_spec(input logic [31:0] value, input logic [6:0] width,
                             input logic signed [7:0] prec, input logic left,
                             input logic zpad);
        t_fmt_in f;
        f.value       = value;
        f.field_width = width;
        f.precision   = prec;
        f.left_align  = left;
        f.zero_pad    = zpad;
        send_field(f);
    endtask

    // Draw a field that mostly stays in range, with some raw encodings mixed in.
    function automatic t_fmt_in rand_field();
        t_fmt_in     f;
        logic [31:0] p;
        int          sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1:    f.value = $urandom_range(9);
            2, 3: begin
                p = 32'd1;
                repeat ($urandom_range(9)) p = p * 10;
                f.value = p - $urandom_range(1);
            end
            4:       f.value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
            5:       f.value = $urandom_range(99999);
            default: f.value = $urandom;
        endcase
        sel = $urandom_range(99);
        if (sel < 80)      f.field_width = 7'($urandom_range(24));
        else if (sel < 92) f.field_width = 7'($urandom_range(64, 25));
        else               f.field_width = 7'($urandom_range(127));
        sel = $urandom_range(99);
        if (sel < 40)      f.precision = -8'sd1;
        else if (sel < 70) f.precision = 8'($urandom_range(12));
        else if (sel < 82) f.precision = 8'($urandom_range(64, 13));
        else               f.precision = 8'($urandom_range(255));
        f.left_align = 1'($urandom_range(1));
        f.zero_pad   = $urandom_range(2) != 0;
        return f;
    endfunction

    // Field extremes, every flag combination and each corner of the rules.
    task automatic test_directed_fields();
        send_spec(32'd0,          7'd0,   -8'sd1,   1'b0, 1'b0);
        send_spec(32'd0,          7'd0,   8'sd0,    1'b0, 1'b0);
        send_spec(32'd0,          7'd5,   8'sd0,    1'b0, 1'b0);
        send_spec(32'd0,          7'd5,   8'sd0,    1'b1, 1'b1);
        send_spec(32'd0,          7'd3,   -8'sd1,   1'b0, 1'b1);
        send_spec(32'hFFFF_FFFF,  7'd0,   -8'sd1,   1'b0, 1'b0);
        send_spec(32'hFFFF_FFFF,  7'd64,  -8'sd1,   1'b0, 1'b1);
        send_spec(32'hFFFF_FFFF,  7'd12,  8'sd10,   1'b1, 1'b0);
        send_spec(32'd42,         7'd10,  -8'sd1,   1'b1, 1'b0);
        send_spec(32'd42,         7'd10,  -8'sd1,   1'b0, 1'b1);
        send_spec(32'd42,         7'd10,  8'sd5,    1'b0, 1'b1);
        send_spec(32'd42,         7'd10,  -8'sd1,   1'b1, 1'b1);
        send_spec(32'd42,         7'd10,  8'sd5,    1'b1, 1'b0);
        send_spec(32'd1,          7'd0,   8'sd64,   1'b0, 1'b0);
        send_spec(32'd9,          7'd127, 8'sd127,  1'b0, 1'b1);
        send_spec(32'd7,          7'd127, -8'sd1,   1'b1, 1'b0);
        send_spec(32'd7,          7'd127, -8'sd1,   1'b0, 1'b1);
        send_spec(32'd123,        7'd8,   -8'sd128, 1'b0, 1'b1);
        send_spec(32'd123,        7'd8,   -8'sd2,   1'b0, 1'b1);
        send_spec(32'd12345,      7'd2,   8'sd3,    1'b0, 1'b0);
        send_spec(32'd1234,       7'd1,   -8'sd1,   1'b0, 1'b0);
        send_spec(32'd1000000000, 7'd11,  -8'sd1,   1'b0, 1'b1);
        send_spec(32'd999999999,  7'd0,   8'sd9,    1'b0, 1'b0);
    endtask

    task automatic test_random_fields();
        repeat (200) send_field(rand_field());
    endtask

    // Run back to back with both sides always ready.
    task automatic test_steady_stream();
        steady = 1'b1;
        repeat (100) send_field(rand_field());
        steady = 1'b0;
    endtask

    // Take result beats and compare each with the oldest expected character.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (exp_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected beat char %h last %b count %0d", $realtime,
                             o_result.char_code, o_result.last, o_result.total_count);
            end else begin
                if (o_result.char_code !== exp_chars[0].char_code ||
                    o_result.last !== exp_chars[0].last ||
                    o_result.total_count !== exp_chars[0].total_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected char %h last %b count %0d, got %h %b %0d",
                                 $realtime, exp_chars[0].char_code, exp_chars[0].last,
                                 exp_chars[0].total_count, o_result.char_code,
                                 o_result.last, o_result.total_count);
                end
                void'(exp_chars.pop_front());
            end
        end
        pop <= i_rst_n && (steady || $urandom_range(99) >= 28);
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_fields();
        test_random_fields();
        test_steady_stream();
        push <= 1'b0;
        // Drain, then give the block time to show any stray characters.
        while (exp_chars.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS unsigned_decimal_field_formatter");
        end else begin
            $display("FAIL unsigned_decimal_field_formatter");
        end
        $finish;
    end

    // Watchdog for a stalled handshake.
    initial begin
        #8_000_000;
        $display("FAIL unsigned_decimal_field_formatter");
        $finish;
    end

endmodule
